// File: hdl/cew_pkg.sv
`timescale 1ns / 1ps

package cew_pkg;

    // coordinate and datapath widths
    localparam int FRAC_BITS_DEF = 16;
    localparam int CW   = 32;   // input coordinate
    localparam int DW   = 33;   // coordinate difference
    localparam int FW   = 32;   // fitted vector component
    localparam int PW   = 64;   // product and cross/dot sums
    localparam int UW   = 62;   // magnitude of cross component or dot
    localparam int KW   = 6;    // bit length of max cross magnitude
    localparam int NW   = 31;   // normalized cross component
    localparam int SW   = 64;   // sum of squares
    localparam int LW   = 32;   // square root
    localparam int QW   = 41;   // quotient, clamped to 2^40
    localparam int COTW = 42;   // signed cotangent
    localparam int OW   = 32;   // output weight

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = QW;
    localparam int ANGLE_LAT  = 9 + SQRT_STEPS + 1 + DIV_STEPS + 1;

    localparam logic [QW-1:0] COT_CLAMP = QW'(1) << (QW - 1);
    localparam logic signed [DW-1:0] COMP_LIMIT = DW'(1) << 30;

    // per-angle status that rides along the datapath
    typedef struct packed {
        logic neg;
        logic deg;
    } cew_flags_t;

    // dividend split and flags carried beside the square root
    typedef struct packed {
        logic          sat;
        logic [LW-1:0] xhi;
        logic [QW-1:0] xlo;
        cew_flags_t    flags;
    } cew_side_t;

    function automatic logic in_limit(input logic signed [DW-1:0] v);
        return (v <= COMP_LIMIT) && (v >= -COMP_LIMIT);
    endfunction

    // least right shift in 0..2 that fits every component into +-2^30
    function automatic logic [1:0] fit_shift(input logic signed [DW-1:0] x,
                                             input logic signed [DW-1:0] y,
                                             input logic signed [DW-1:0] z);
        logic ok0;
        logic ok1;
        ok0 = in_limit(x) && in_limit(y) && in_limit(z);
        ok1 = in_limit(x >>> 1) && in_limit(y >>> 1) && in_limit(z >>> 1);
        if (ok0)
            return 2'd0;
        else if (ok1)
            return 2'd1;
        else
            return 2'd2;
    endfunction

endpackage

// File: hdl/cew_isqrt.sv
`timescale 1ns / 1ps

module cew_isqrt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [63:0]           n,
    input  cew_pkg::cew_side_t    side_in,
    output logic                  out_valid,
    output logic [cew_pkg::LW-1:0] root,
    output cew_pkg::cew_side_t    side_out
);
    import cew_pkg::*;

    logic [SQRT_STEPS-1:0] v_reg;
    logic [63:0]           n_reg    [SQRT_STEPS];
    logic [63:0]           res_reg  [SQRT_STEPS];
    cew_side_t             side_reg [SQRT_STEPS];

    // one digit-pair of the restoring square root per stage
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] n_src;
        logic [63:0] r_src;
        logic        v_src;
        cew_side_t   s_src;
        logic [63:0] trial;

        if (j == 0) begin : g_first
            assign n_src = n;
            assign r_src = '0;
            assign v_src = in_valid;
            assign s_src = side_in;
        end
        else begin : g_next
            assign n_src = n_reg[j-1];
            assign r_src = res_reg[j-1];
            assign v_src = v_reg[j-1];
            assign s_src = side_reg[j-1];
        end

        assign trial = r_src + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else
                v_reg[j] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (n_src >= trial)
            begin
                n_reg[j]   <= n_src - trial;
                res_reg[j] <= (r_src >> 1) + BIT;
            end
            else
            begin
                n_reg[j]   <= n_src;
                res_reg[j] <= r_src >> 1;
            end
            side_reg[j] <= s_src;
        end
    end

    assign out_valid = v_reg[SQRT_STEPS-1];
    assign root      = res_reg[SQRT_STEPS-1][LW-1:0];
    assign side_out  = side_reg[SQRT_STEPS-1];

endmodule

// File: hdl/cew_qdiv.sv
`timescale 1ns / 1ps

module cew_qdiv (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [cew_pkg::LW-1:0] l,
    input  cew_pkg::cew_side_t     side_in,
    output logic                   out_valid,
    output logic [cew_pkg::QW-1:0] q,
    output cew_pkg::cew_flags_t    flags
);
    import cew_pkg::*;

    // setup stage: high part of the dividend against the divisor
    logic          v0_reg;
    logic [LW-1:0] r0_reg;
    logic [LW-1:0] l0_reg;
    logic [QW-1:0] xlo0_reg;
    logic          sat0_reg;
    cew_flags_t    flags0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        r0_reg     <= side_in.xhi;
        l0_reg     <= l;
        xlo0_reg   <= side_in.xlo;
        sat0_reg   <= side_in.sat | (side_in.xhi >= l);
        flags0_reg <= side_in.flags;
    end

    logic [DIV_STEPS-1:0] v_reg;
    logic [LW-1:0]        r_reg     [DIV_STEPS];
    logic [QW-1:0]        q_reg     [DIV_STEPS];
    logic [LW-1:0]        l_reg     [DIV_STEPS];
    logic [QW-1:0]        xlo_reg   [DIV_STEPS];
    logic                 sat_reg   [DIV_STEPS];
    cew_flags_t           flags_reg [DIV_STEPS];

    // one quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        logic [LW-1:0] r_src;
        logic [QW-1:0] q_src;
        logic [LW-1:0] l_src;
        logic [QW-1:0] x_src;
        logic          s_src;
        logic          v_src;
        cew_flags_t    f_src;
        logic [LW:0]   r2;
        logic          ge;

        if (j == 0) begin : g_first
            assign r_src = r0_reg;
            assign q_src = '0;
            assign l_src = l0_reg;
            assign x_src = xlo0_reg;
            assign s_src = sat0_reg;
            assign v_src = v0_reg;
            assign f_src = flags0_reg;
        end
        else begin : g_next
            assign r_src = r_reg[j-1];
            assign q_src = q_reg[j-1];
            assign l_src = l_reg[j-1];
            assign x_src = xlo_reg[j-1];
            assign s_src = sat_reg[j-1];
            assign v_src = v_reg[j-1];
            assign f_src = flags_reg[j-1];
        end

        assign r2 = {r_src, x_src[QW-1-j]};
        assign ge = r2 >= {1'b0, l_src};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else
                v_reg[j] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            r_reg[j]     <= ge ? LW'(r2 - {1'b0, l_src}) : r2[LW-1:0];
            q_reg[j]     <= {q_src[QW-2:0], ge};
            l_reg[j]     <= l_src;
            xlo_reg[j]   <= x_src;
            sat_reg[j]   <= s_src;
            flags_reg[j] <= f_src;
        end
    end

    // clamp to 2^40
    logic          vo_reg;
    logic [QW-1:0] q_out_reg;
    cew_flags_t    flags_out_reg;
    logic [QW-1:0] q_last;

    assign q_last = q_reg[DIV_STEPS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else
            vo_reg <= v_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (sat_reg[DIV_STEPS-1] || (q_last > COT_CLAMP))
            q_out_reg <= COT_CLAMP;
        else
            q_out_reg <= q_last;
        flags_out_reg <= flags_reg[DIV_STEPS-1];
    end

    assign out_valid = vo_reg;
    assign q         = q_out_reg;
    assign flags     = flags_out_reg;

endmodule

// File: hdl/cew_angle.sv
`timescale 1ns / 1ps

module cew_angle #(
    parameter int FRAC_BITS = cew_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic signed [cew_pkg::DW-1:0]   a [3],
    input  logic signed [cew_pkg::DW-1:0]   b [3],
    output logic                            out_valid,
    output logic signed [cew_pkg::COTW-1:0] cot,
    output logic                            deg
);
    import cew_pkg::*;

    localparam int XW = UW + FRAC_BITS + 32;

    // stage 1: fit each vector into +-2^30
    logic                 v1_reg;
    logic signed [FW-1:0] af_reg [3];
    logic signed [FW-1:0] bf_reg [3];
    logic [1:0]           sh_a;
    logic [1:0]           sh_b;

    assign sh_a = fit_shift(a[0], a[1], a[2]);
    assign sh_b = fit_shift(b[0], b[1], b[2]);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            af_reg[i] <= FW'(a[i] >>> sh_a);
            bf_reg[i] <= FW'(b[i] >>> sh_b);
        end
    end

    // stage 2: the nine products
    logic                 v2_reg;
    logic signed [PW-1:0] prod_reg [9];

    always_ff @(posedge clk)
    begin
        prod_reg[0] <= af_reg[1] * bf_reg[2];
        prod_reg[1] <= af_reg[2] * bf_reg[1];
        prod_reg[2] <= af_reg[2] * bf_reg[0];
        prod_reg[3] <= af_reg[0] * bf_reg[2];
        prod_reg[4] <= af_reg[0] * bf_reg[1];
        prod_reg[5] <= af_reg[1] * bf_reg[0];
        prod_reg[6] <= af_reg[0] * bf_reg[0];
        prod_reg[7] <= af_reg[1] * bf_reg[1];
        prod_reg[8] <= af_reg[2] * bf_reg[2];
    end

    // stage 3: cross and dot
    logic                 v3_reg;
    logic signed [PW-1:0] c_reg [3];
    logic signed [PW-1:0] d_reg;

    always_ff @(posedge clk)
    begin
        c_reg[0] <= prod_reg[0] - prod_reg[1];
        c_reg[1] <= prod_reg[2] - prod_reg[3];
        c_reg[2] <= prod_reg[4] - prod_reg[5];
        d_reg    <= prod_reg[6] + prod_reg[7] + prod_reg[8];
    end

    // stage 4: magnitudes
    logic          v4_reg;
    logic [UW-1:0] u4_reg [3];
    logic [UW-1:0] ad4_reg;
    logic          neg4_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            u4_reg[i] <= c_reg[i][PW-1] ? UW'(-c_reg[i]) : UW'(c_reg[i]);
        ad4_reg  <= d_reg[PW-1] ? UW'(-d_reg) : UW'(d_reg);
        neg4_reg <= d_reg[PW-1];
    end

    // stage 5: largest cross magnitude
    logic          v5_reg;
    logic [UW-1:0] u5_reg [3];
    logic [UW-1:0] m5_reg;
    logic [UW-1:0] ad5_reg;
    logic          neg5_reg;
    logic [UW-1:0] m01;

    assign m01 = (u4_reg[0] > u4_reg[1]) ? u4_reg[0] : u4_reg[1];

    always_ff @(posedge clk)
    begin
        u5_reg   <= u4_reg;
        m5_reg   <= (m01 > u4_reg[2]) ? m01 : u4_reg[2];
        ad5_reg  <= ad4_reg;
        neg5_reg <= neg4_reg;
    end

    // stage 6: bit length of the maximum
    logic          v6_reg;
    logic [UW-1:0] u6_reg [3];
    logic [KW-1:0] k6_reg;
    logic [UW-1:0] ad6_reg;
    logic          neg6_reg;
    logic          deg6_reg;
    logic [KW-1:0] k_next;

    always_comb
    begin
        k_next = '0;
        for (int i = 0; i < UW; i++)
            if (m5_reg[i])
                k_next = KW'(i + 1);
    end

    always_ff @(posedge clk)
    begin
        u6_reg   <= u5_reg;
        k6_reg   <= k_next;
        ad6_reg  <= ad5_reg;
        neg6_reg <= neg5_reg;
        deg6_reg <= (m5_reg == '0);
    end

    // stage 7: normalize cross and scale the dot into the dividend
    logic              v7_reg;
    logic [NW-1:0]     nu7_reg [3];
    cew_side_t         side7_reg;
    logic [UW+NW-1:0]  uw [3];
    logic [XW-1:0]     x_full;
    logic [KW:0]       x_sh;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            uw[i] = {u6_reg[i], {NW{1'b0}}} >> k6_reg;
        x_sh   = {1'b0, k6_reg} + (KW+1)'(1);
        x_full = {ad6_reg, {(FRAC_BITS + 32){1'b0}}} >> x_sh;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            nu7_reg[i] <= uw[i][NW-1:0];
        side7_reg.sat       <= |x_full[XW-1:QW+LW];
        side7_reg.xhi       <= x_full[QW +: LW];
        side7_reg.xlo       <= x_full[QW-1:0];
        side7_reg.flags.neg <= neg6_reg;
        side7_reg.flags.deg <= deg6_reg;
    end

    // stage 8: squares
    logic            v8_reg;
    logic [2*NW-1:0] sq8_reg [3];
    cew_side_t       side8_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            sq8_reg[i] <= nu7_reg[i] * nu7_reg[i];
        side8_reg <= side7_reg;
    end

    // stage 9: sum of squares
    logic          v9_reg;
    logic [SW-1:0] n9_reg;
    cew_side_t     side9_reg;

    always_ff @(posedge clk)
    begin
        n9_reg    <= SW'(sq8_reg[0]) + SW'(sq8_reg[1]) + SW'(sq8_reg[2]);
        side9_reg <= side8_reg;
    end

    // valid bits of stages 1 to 9
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    // length of the cross product
    logic          sq_valid;
    logic [LW-1:0] root;
    cew_side_t     sq_side;

    cew_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v9_reg),
        .n         (n9_reg),
        .side_in   (side9_reg),
        .out_valid (sq_valid),
        .root      (root),
        .side_out  (sq_side)
    );

    // |dot| scaled over the length
    logic          dv_valid;
    logic [QW-1:0] q;
    cew_flags_t    flags;

    cew_qdiv u_qdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .l         (root),
        .side_in   (sq_side),
        .out_valid (dv_valid),
        .q         (q),
        .flags     (flags)
    );

    assign out_valid = dv_valid;
    assign cot       = flags.neg ? -COTW'(q) : COTW'(q);
    assign deg       = flags.deg;

endmodule

// File: hdl/cotangent_edge_weight_top.sv
`timescale 1ns / 1ps
// throughput: one edge per cycle; busy stays low, the pipeline never stalls
// most of the latency is the 32-stage square root and 41-stage divider pipelines
// reset clears all valid bits; payload registers are not reset
// the receiver cannot stall: each result is shown for one cycle with done

module cotangent_edge_weight_top #(
    parameter int FRAC_BITS = cew_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [cew_pkg::CW-1:0] p_x,
    input  logic signed [cew_pkg::CW-1:0] p_y,
    input  logic signed [cew_pkg::CW-1:0] p_z,
    input  logic signed [cew_pkg::CW-1:0] q_x,
    input  logic signed [cew_pkg::CW-1:0] q_y,
    input  logic signed [cew_pkg::CW-1:0] q_z,
    input  logic signed [cew_pkg::CW-1:0] r_x,
    input  logic signed [cew_pkg::CW-1:0] r_y,
    input  logic signed [cew_pkg::CW-1:0] r_z,
    input  logic signed [cew_pkg::CW-1:0] s_x,
    input  logic signed [cew_pkg::CW-1:0] s_y,
    input  logic signed [cew_pkg::CW-1:0] s_z,
    output logic                          done,
    output logic signed [cew_pkg::OW-1:0] weight,
    output logic                          degenerate
);
    import cew_pkg::*;

    localparam int TOP_LAT = ANGLE_LAT + 2;
    localparam logic signed [COTW:0] W_MAX = (COTW+1)'(33'sh0_7FFF_FFFF);
    localparam logic signed [COTW:0] W_MIN = -(COTW+1)'(33'sh0_8000_0000);

    assign busy = 1'b0;

    // side vectors of both angles
    logic                 v_in_reg;
    logic signed [DW-1:0] sa_reg [3];
    logic signed [DW-1:0] sb_reg [3];
    logic signed [DW-1:0] ra_reg [3];
    logic signed [DW-1:0] rb_reg [3];
    logic signed [DW-1:0] pe [3];
    logic signed [DW-1:0] qe [3];
    logic signed [DW-1:0] re [3];
    logic signed [DW-1:0] se [3];

    assign pe[0] = DW'(p_x);
    assign pe[1] = DW'(p_y);
    assign pe[2] = DW'(p_z);
    assign qe[0] = DW'(q_x);
    assign qe[1] = DW'(q_y);
    assign qe[2] = DW'(q_z);
    assign re[0] = DW'(r_x);
    assign re[1] = DW'(r_y);
    assign re[2] = DW'(r_z);
    assign se[0] = DW'(s_x);
    assign se[1] = DW'(s_y);
    assign se[2] = DW'(s_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_in_reg <= 1'b0;
        else
            v_in_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sa_reg[i] <= pe[i] - se[i];
            sb_reg[i] <= qe[i] - se[i];
            ra_reg[i] <= pe[i] - re[i];
            rb_reg[i] <= qe[i] - re[i];
        end
    end

    // cotangent at S and at R
    logic                   s_valid;
    logic                   r_valid;
    logic signed [COTW-1:0] cot_s;
    logic signed [COTW-1:0] cot_r;
    logic                   deg_s;
    logic                   deg_r;

    cew_angle #(.FRAC_BITS(FRAC_BITS)) u_angle_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_in_reg),
        .a         (sa_reg),
        .b         (sb_reg),
        .out_valid (s_valid),
        .cot       (cot_s),
        .deg       (deg_s)
    );

    cew_angle #(.FRAC_BITS(FRAC_BITS)) u_angle_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_in_reg),
        .a         (ra_reg),
        .b         (rb_reg),
        .out_valid (r_valid),
        .cot       (cot_r),
        .deg       (deg_r)
    );

    // weight = floor(-(cotS+cotR)/2), saturated
    logic                 done_reg;
    logic signed [OW-1:0] weight_reg;
    logic                 degenerate_reg;
    logic signed [COTW:0] neg_sum;
    logic signed [COTW:0] half;

    assign neg_sum = -((COTW+1)'(cot_s) + (COTW+1)'(cot_r));
    assign half    = neg_sum >>> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s_valid;
    end

    always_ff @(posedge clk)
    begin
        if (deg_s || deg_r)
        begin
            weight_reg     <= '0;
            degenerate_reg <= 1'b1;
        end
        else
        begin
            degenerate_reg <= 1'b0;
            if (half > W_MAX)
                weight_reg <= OW'(W_MAX);
            else if (half < W_MIN)
                weight_reg <= OW'(W_MIN);
            else
                weight_reg <= OW'(half);
        end
    end

    assign done       = done_reg;
    assign weight     = weight_reg;
    assign degenerate = degenerate_reg;

    // every accepted beat returns exactly after the pipeline latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##TOP_LAT done)
        else $error("result strobe missing after pipeline latency");

    // both angle pipelines stay in lockstep
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid == r_valid)
        else $error("angle pipelines out of step");

    // two non-negative cotangents never give a positive weight
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid && !deg_s && !deg_r && !cot_s[COTW-1] && !cot_r[COTW-1])
        |=> (weight[OW-1] || (weight == '0)))
        else $error("weight sign wrong for non-negative cotangents");

    // a degenerate beat always carries a zero weight
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (weight == '0))
        else $error("degenerate beat with nonzero weight");

endmodule

// File: tb/cew_checker.sv
`timescale 1ns / 1ps

module cew_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic signed [cew_pkg::CW-1:0] p_x,
    input  logic signed [cew_pkg::CW-1:0] p_y,
    input  logic signed [cew_pkg::CW-1:0] p_z,
    input  logic signed [cew_pkg::CW-1:0] q_x,
    input  logic signed [cew_pkg::CW-1:0] q_y,
    input  logic signed [cew_pkg::CW-1:0] q_z,
    input  logic signed [cew_pkg::CW-1:0] r_x,
    input  logic signed [cew_pkg::CW-1:0] r_y,
    input  logic signed [cew_pkg::CW-1:0] r_z,
    input  logic signed [cew_pkg::CW-1:0] s_x,
    input  logic signed [cew_pkg::CW-1:0] s_y,
    input  logic signed [cew_pkg::CW-1:0] s_z,
    input  logic                          done,
    input  logic signed [cew_pkg::OW-1:0] weight,
    input  logic                          degenerate,
    output int                            errors,
    output int                            pending
);
    import cew_pkg::*;

    typedef longint vec3_t [3];

    typedef struct {
        logic signed [OW-1:0] weight;
        logic                 degenerate;
    } edge_weight_t;

    edge_weight_t weights_due [$];

    localparam longint unsigned CLAMP_LIM = 64'd1 << 40;
    localparam longint LIM = 64'sd1 << 30;

    // scale one side vector so every component fits in +-2^30
    function automatic vec3_t fit_side(input vec3_t v);
        vec3_t o;
        int s;
        bit ok;
        for (s = 0; s < 2; s++) begin
            ok = 1;
            for (int i = 0; i < 3; i++)
                if ((v[i] >>> s) > LIM || (v[i] >>> s) < -LIM)
                    ok = 0;
            if (ok)
                break;
        end
        for (int i = 0; i < 3; i++)
            o[i] = v[i] >>> s;
        return o;
    endfunction

    // cotangent of the angle between a and b; 0 return means degenerate
    function automatic bit angle_cot(input vec3_t a_in, input vec3_t b_in,
                                     output longint cot);
        vec3_t a;
        vec3_t b;
        longint c [3];
        longint d;
        longint unsigned u [3];
        longint unsigned m;
        longint unsigned n;
        longint unsigned len;
        longint unsigned rem;
        longint unsigned bitv;
        longint unsigned ad;
        longint unsigned q;
        longint unsigned r;
        int k;
        int e;
        a = fit_side(a_in);
        b = fit_side(b_in);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        m = 0;
        for (int i = 0; i < 3; i++) begin
            u[i] = (c[i] < 0) ? -c[i] : c[i];
            if (u[i] > m)
                m = u[i];
        end
        cot = 0;
        if (m == 0)
            return 0;
        k = 0;
        while ((m >> k) != 0)
            k++;
        n = 0;
        for (int i = 0; i < 3; i++) begin
            if (k > 31)
                u[i] = u[i] >> (k - 31);
            else
                u[i] = u[i] << (31 - k);
            n += u[i] * u[i];
        end
        // integer square root
        len = 0;
        rem = n;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= len + bitv) begin
                rem = rem - (len + bitv);
                len = (len >> 1) + bitv;
            end
            else
                len = len >> 1;
            bitv = bitv >> 2;
        end
        // scaled quotient, truncated and clamped
        ad = (d < 0) ? -d : d;
        e = FRAC_BITS_DEF + 31 - k;
        q = ad / len;
        if (e <= 0)
            q = q >> (-e);
        else begin
            r = ad % len;
            for (int i = 0; i < e; i++) begin
                if (q > CLAMP_LIM)
                    break;
                q = q << 1;
                r = r << 1;
                if (r >= len) begin
                    q++;
                    r -= len;
                end
            end
        end
        if (q > CLAMP_LIM)
            q = CLAMP_LIM;
        cot = (d < 0) ? -longint'(q) : longint'(q);
        return 1;
    endfunction

    // expected weight of the current input beat
    function automatic edge_weight_t edge_weight();
        edge_weight_t res;
        vec3_t pv;
        vec3_t qv;
        vec3_t rv;
        vec3_t sv;
        vec3_t sa;
        vec3_t sb;
        vec3_t ra;
        vec3_t rb;
        longint cs;
        longint cr;
        longint ng;
        longint w;
        bit oks;
        bit okr;
        pv = '{longint'(p_x), longint'(p_y), longint'(p_z)};
        qv = '{longint'(q_x), longint'(q_y), longint'(q_z)};
        rv = '{longint'(r_x), longint'(r_y), longint'(r_z)};
        sv = '{longint'(s_x), longint'(s_y), longint'(s_z)};
        for (int i = 0; i < 3; i++) begin
            sa[i] = pv[i] - sv[i];
            sb[i] = qv[i] - sv[i];
            ra[i] = pv[i] - rv[i];
            rb[i] = qv[i] - rv[i];
        end
        oks = angle_cot(sa, sb, cs);
        okr = angle_cot(ra, rb, cr);
        if (!oks || !okr) begin
            res.weight = '0;
            res.degenerate = 1'b1;
            return res;
        end
        ng = -(cs + cr);
        if (ng >= 0)
            w = ng / 2;
        else
            w = -((-ng + 1) / 2);
        if (w > 64'sd2147483647)
            w = 64'sd2147483647;
        if (w < -64'sd2147483648)
            w = -64'sd2147483648;
        res.weight = w[OW-1:0];
        res.degenerate = 1'b0;
        return res;
    endfunction

    initial errors = 0;
    assign pending = weights_due.size();

    // predict on each input beat, compare on each result beat
    always @(posedge clk) begin
        edge_weight_t exp_w;
        if (rst_n && done) begin
            if (weights_due.size() == 0) begin
                $display("%0t: result with nothing expected: weight %0d degenerate %0b",
                         $time, weight, degenerate);
                errors++;
            end
            else begin
                exp_w = weights_due.pop_front();
                if (weight !== exp_w.weight) begin
                    $display("%0t: weight expected %0d actual %0d",
                             $time, exp_w.weight, weight);
                    errors++;
                end
                if (degenerate !== exp_w.degenerate) begin
                    $display("%0t: degenerate expected %0b actual %0b",
                             $time, exp_w.degenerate, degenerate);
                    errors++;
                end
            end
        end
        if (rst_n && start && !busy)
            weights_due.push_back(edge_weight());
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import cew_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 120;
    localparam int NUM_RANDOM = 400;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [CW-1:0] p_x, p_y, p_z, q_x, q_y, q_z;
    logic signed [CW-1:0] r_x, r_y, r_z, s_x, s_y, s_z;
    logic done;
    logic signed [OW-1:0] weight;
    logic degenerate;
    int errors;
    int pending;
    int quiet_cycles;
    int idle_pct;

    typedef int edge_pts_t [12];

    cotangent_edge_weight_top dut (.*);

    cew_checker u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge clk) begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("cotangent_edge_weight_top verification failed");
            $finish;
        end
    end

    // one edge beat, with a random idle gap before it
    task automatic send_edge(input edge_pts_t c);
        int gap;
        gap = 0;
        if (idle_pct > 0)
            while ($urandom_range(99) < idle_pct)
                gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        {p_x, p_y, p_z} <= {c[0], c[1], c[2]};
        {q_x, q_y, q_z} <= {c[3], c[4], c[5]};
        {r_x, r_y, r_z} <= {c[6], c[7], c[8]};
        {s_x, s_y, s_z} <= {c[9], c[10], c[11]};
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // random coordinate within +-2^bits
    function automatic int rnd_coord(input int bits);
        if (bits >= 31)
            return int'($urandom);
        return int'($urandom_range(2 ** (bits + 1))) - 2 ** bits;
    endfunction

    task automatic random_edge();
        edge_pts_t c;
        int kind;
        int bits;
        int t;
        kind = $urandom_range(99);
        bits = (kind < 20) ? 31 : $urandom_range(30, 4);
        for (int i = 0; i < 12; i++)
            c[i] = rnd_coord(bits);
        if (kind >= 85 && kind < 93) begin
            // R on the line through P and Q
            t = $urandom_range(4) - 2;
            for (int i = 0; i < 3; i++)
                c[6 + i] = c[i] + t * (c[3 + i] - c[i]) / 2;
        end
        else if (kind >= 93 && kind < 96) begin
            // S close to the edge: thin triangle, huge cotangent
            for (int i = 0; i < 3; i++)
                c[9 + i] = c[i] + int'($urandom_range(2)) - 1;
        end
        else if (kind >= 96) begin
            // zero-length edge
            for (int i = 0; i < 3; i++)
                c[3 + i] = c[i];
        end
        send_edge(c);
    endtask

    localparam int MX = 32'h7fffffff;
    localparam int MN = 32'h80000000;
    localparam int ONE = 32'h00010000;

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        {p_x, p_y, p_z, q_x, q_y, q_z} = '0;
        {r_x, r_y, r_z, s_x, s_y, s_z} = '0;
        quiet_cycles = 0;
        idle_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed edges
        send_edge('{default: 0});
        send_edge('{default: MX});
        send_edge('{default: MN});
        // right angles at R and S: weight zero
        send_edge('{0, 0, 0, ONE, ONE, 0, ONE, 0, 0, 0, ONE, 0});
        // isosceles right triangles on both sides of the edge
        send_edge('{0, 0, 0, 2 * ONE, 0, 0, ONE, ONE, 0, ONE, -ONE, 0});
        // obtuse angles give positive weight
        send_edge('{0, 0, 0, 4 * ONE, 0, 0, 2 * ONE, ONE / 4, 0,
                    2 * ONE, -ONE / 4, ONE / 8});
        // thin triangles, clamped cotangent and saturated weight
        send_edge('{0, 0, 0, MX, 0, 0, 100, 1, 0, 200, -1, 0});
        send_edge('{MN, MN, MN, MX, MX, MX, 0, 0, 1, 1, 0, 0});
        // collinear vertex
        send_edge('{0, 0, 0, 4 * ONE, 0, 0, 8 * ONE, 0, 0, ONE, ONE, 0});
        // R on P
        send_edge('{ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE, 0, ONE, 0});
        // extreme spans that need the largest fit shift
        send_edge('{MX, MN, MX, MN, MX, MN, MN, MN, MX, MX, MX, MN});
        send_edge('{MX, 0, 0, 0, MX, 0, MN, MN, MN, 0, 0, MX});
        send_edge('{MN, MX, 0, MX, MN, 0, 0, 0, MX, 0, 0, MN});
        send_edge('{-1, -1, -1, 1, 1, 1, 1, -1, 0, -1, 1, 0});

        // random edges over several idle settings
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 51 : (ph == 2) ? 6 : 0;
            for (int n = 0; n < NUM_RANDOM / 4; n++)
                random_edge();
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("cotangent_edge_weight_top verification clean");
        else
            $display("cotangent_edge_weight_top verification failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/cew_pkg.sv
hdl/cew_isqrt.sv
hdl/cew_qdiv.sv
hdl/cew_angle.sv
hdl/cotangent_edge_weight_top.sv
tb/cew_checker.sv
tb/tb.sv
